>>> sv/assert_macros.svh
// Assertion macros for the port-level checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at each rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Checks a property at each rising clock edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

>>> sv/cgc_pkg.sv
// Types and codes shared by the conflict graph coloring block.
package cgc_pkg;

  localparam logic [1:0] OP_ADD_VERTEX = 2'd0;
  localparam logic [1:0] OP_ADD_EDGE   = 2'd1;
  localparam logic [1:0] OP_COLOR      = 2'd2;
  localparam logic [1:0] OP_UNUSED     = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SELF_EDGE = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;

  localparam logic [1:0] K_ACK    = 2'd0;
  localparam logic [1:0] K_VERTEX = 2'd1;
  localparam logic [1:0] K_EDGE   = 2'd2;
  localparam logic [1:0] K_COLOR  = 2'd3;

  localparam logic [5:0] LAST_COLOR = 6'd63;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] vertex_a;
    logic [5:0] vertex_b;
  } in_t;

  typedef struct packed {
    logic [5:0] vertex_id;
    logic [5:0] assigned_color;
    logic       last;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic [5:0] a;
    logic [5:0] b;
  } cmd_t;

endpackage

>>> sv/cgc_front.sv
// Front end: accepts commands and classifies them for the back end.
module cgc_front #(
  parameter int NV = 64
) (
  input  cgc_pkg::in_t  cmd,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  logic          q_full,
  output logic          push,
  output cgc_pkg::cmd_t push_cmd
);
  import cgc_pkg::*;

  logic a_ok;
  logic b_ok;

  assign a_ok = {1'b0, cmd.vertex_a} < 7'(NV);
  assign b_ok = {1'b0, cmd.vertex_b} < 7'(NV);
  assign cmd_stall = q_full;
  assign push = cmd_valid && !q_full;

  always_comb begin
    push_cmd.a = cmd.vertex_a;
    push_cmd.b = cmd.vertex_b;
    push_cmd.kind = K_ACK;
    push_cmd.status = ST_OK;
    unique case (cmd.opcode)
      OP_ADD_VERTEX: begin
        if (a_ok) push_cmd.kind = K_VERTEX;
      end
      OP_ADD_EDGE: begin
        if (cmd.vertex_a == cmd.vertex_b) push_cmd.status = ST_SELF_EDGE;
        else if (a_ok && b_ok) push_cmd.kind = K_EDGE;
      end
      OP_COLOR: push_cmd.kind = K_COLOR;
      default: push_cmd.kind = K_ACK;
    endcase
  end
endmodule

>>> sv/cgc_queue.sv
// Two-entry command queue between the front and back ends.
module cgc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cgc_pkg::cmd_t din,
  input  logic          pop,
  output cgc_pkg::cmd_t dout,
  output logic          full,
  output logic          empty
);
  import cgc_pkg::*;

  cmd_t       entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign empty = count == 2'd0;
  assign dout = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> sv/cgc_back.sv
// Back end: graph storage, greedy coloring sequencer and result register.
module cgc_back #(
  parameter int NV = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  cgc_pkg::cmd_t q_cmd,
  output logic          pop,
  output cgc_pkg::out_t res,
  output logic          res_valid,
  input  logic          res_stall
);
  import cgc_pkg::*;

  localparam int IW = $clog2(NV);
  localparam int CW = $clog2(NV + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NV - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACK  = 4'd1;
  localparam logic [3:0] S_ERDA = 4'd2;
  localparam logic [3:0] S_ECHK = 4'd3;
  localparam logic [3:0] S_EWB  = 4'd4;
  localparam logic [3:0] S_SRD  = 4'd5;
  localparam logic [3:0] S_SEV  = 4'd6;
  localparam logic [3:0] S_ROW  = 4'd7;
  localparam logic [3:0] S_RLAT = 4'd8;
  localparam logic [3:0] S_URD  = 4'd9;
  localparam logic [3:0] S_UEV  = 4'd10;
  localparam logic [3:0] S_FREE = 4'd11;
  localparam logic [3:0] S_ORD  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0]    state;
  cmd_t          cur;
  logic [1:0]    ack_status;
  logic [NV-1:0] present;
  logic [NV-1:0] colored;
  logic [NV-1:0] rowreg;
  logic [CW-1:0] cnt;
  logic [CW-1:0] remain;
  logic [IW-1:0] best;
  logic [6:0]    bestdeg;
  logic          found;
  logic [IW-1:0] sv;
  logic [IW-1:0] uv;
  logic [IW-1:0] ev;
  logic [5:0]    fc;
  logic [63:0]   used;

  logic [NV-1:0] adj_mem [NV];
  logic [NV-1:0] adj_vld;
  logic [NV-1:0] adj_q;
  logic [6:0]    deg_mem [NV];
  logic [NV-1:0] deg_vld;
  logic [6:0]    deg_q;
  logic [5:0]    col_mem [NV];
  logic [5:0]    col_q;

  logic [IW-1:0] ia;
  logic [IW-1:0] ib;
  logic [IW-1:0] hia;
  logic [IW-1:0] hib;
  logic [IW-1:0] adj_raddr;
  logic [IW-1:0] deg_raddr;
  logic          adj_we;
  logic [IW-1:0] adj_waddr;
  logic [NV-1:0] adj_wdata;
  logic          deg_we;
  logic [IW-1:0] deg_waddr;
  logic [6:0]    deg_wdata;
  logic          col_re;
  logic [IW-1:0] col_raddr;
  logic          col_we;
  logic          dup;
  logic          slot_free;
  logic          load;
  out_t          load_pay;
  logic          take;
  logic          free_done;

  assign ia = cur.a[IW-1:0];
  assign ib = cur.b[IW-1:0];
  assign hia = q_cmd.a[IW-1:0];
  assign hib = q_cmd.b[IW-1:0];
  assign dup = adj_q[ib];
  assign slot_free = !res_valid || !res_stall;
  assign pop = (state == S_IDLE) && !q_empty;
  assign take = present[sv] && !colored[sv] && (!found || deg_q > bestdeg);
  assign free_done = !used[fc] || (fc == LAST_COLOR);

  always_comb begin
    adj_raddr = best;
    deg_raddr = sv;
    if (state == S_ERDA) begin
      adj_raddr = ia;
      deg_raddr = ia;
    end else if (state == S_ECHK) begin
      adj_raddr = ib;
      deg_raddr = ib;
    end
    adj_we = 1'b0;
    adj_waddr = ia;
    adj_wdata = adj_q | (NV'(1) << ib);
    deg_we = 1'b0;
    deg_waddr = ia;
    deg_wdata = deg_q + 7'd1;
    if (state == S_ECHK && !dup) begin
      adj_we = 1'b1;
      deg_we = 1'b1;
    end else if (state == S_EWB) begin
      adj_we = 1'b1;
      adj_waddr = ib;
      adj_wdata = adj_q | (NV'(1) << ia);
      deg_we = 1'b1;
      deg_waddr = ib;
    end
    col_raddr = (state == S_URD) ? uv : ev;
    col_re = ((state == S_URD) && rowreg[uv]) || ((state == S_ORD) && present[ev]);
    col_we = (state == S_FREE) && free_done;
  end

  always_comb begin
    load = 1'b0;
    load_pay.vertex_id = 6'd0;
    load_pay.assigned_color = 6'd0;
    load_pay.last = 1'b1;
    load_pay.status = ack_status;
    if (state == S_ACK && slot_free) begin
      load = 1'b1;
    end else if (state == S_OUT && slot_free) begin
      load = 1'b1;
      load_pay.vertex_id = 6'(ev);
      load_pay.assigned_color = col_q;
      load_pay.last = remain == CW'(1);
      load_pay.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    adj_q <= adj_vld[adj_raddr] ? adj_mem[adj_raddr] : '0;
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    deg_q <= deg_vld[deg_raddr] ? deg_mem[deg_raddr] : 7'd0;
    if (col_we) col_mem[best] <= fc;
    if (col_re) col_q <= col_mem[col_raddr];
  end

  always_ff @(posedge clk) begin
    if (load) res <= load_pay;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      adj_vld <= '0;
      deg_vld <= '0;
      present <= '0;
      colored <= '0;
      cnt <= '0;
      res_valid <= 1'b0;
    end else begin
      if (adj_we) adj_vld[adj_waddr] <= 1'b1;
      if (deg_we) deg_vld[deg_waddr] <= 1'b1;
      if (load) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur <= q_cmd;
            ack_status <= q_cmd.status;
            unique case (q_cmd.kind)
              K_VERTEX: begin
                present[hia] <= 1'b1;
                cnt <= cnt + CW'(!present[hia]);
                state <= S_ACK;
              end
              K_EDGE: begin
                present[hia] <= 1'b1;
                present[hib] <= 1'b1;
                cnt <= cnt + CW'(!present[hia]) + CW'(!present[hib]);
                state <= S_ERDA;
              end
              K_COLOR: begin
                if (cnt == '0) begin
                  ack_status <= ST_EMPTY;
                  state <= S_ACK;
                end else begin
                  colored <= '0;
                  sv <= '0;
                  found <= 1'b0;
                  state <= S_SRD;
                end
              end
              default: state <= S_ACK;
            endcase
          end
        end
        S_ACK: begin
          if (slot_free) state <= S_IDLE;
        end
        S_ERDA: state <= S_ECHK;
        S_ECHK: state <= dup ? S_ACK : S_EWB;
        S_EWB: state <= S_ACK;
        S_SRD: state <= S_SEV;
        S_SEV: begin
          if (take) begin
            best <= sv;
            bestdeg <= deg_q;
            found <= 1'b1;
          end
          if (sv == LAST_IDX) begin
            if (found || take) begin
              state <= S_ROW;
            end else begin
              ev <= '0;
              remain <= cnt;
              state <= S_ORD;
            end
          end else begin
            sv <= sv + IW'(1);
            state <= S_SRD;
          end
        end
        S_ROW: state <= S_RLAT;
        S_RLAT: begin
          rowreg <= adj_q & colored;
          uv <= '0;
          used <= '0;
          fc <= '0;
          state <= S_URD;
        end
        S_URD: begin
          if (rowreg[uv]) state <= S_UEV;
          else if (uv == LAST_IDX) state <= S_FREE;
          else uv <= uv + IW'(1);
        end
        S_UEV: begin
          used <= used | (64'(1) << col_q);
          if (uv == LAST_IDX) begin
            state <= S_FREE;
          end else begin
            uv <= uv + IW'(1);
            state <= S_URD;
          end
        end
        S_FREE: begin
          if (free_done) begin
            colored[best] <= 1'b1;
            sv <= '0;
            found <= 1'b0;
            state <= S_SRD;
          end else begin
            fc <= fc + 6'd1;
          end
        end
        S_ORD: begin
          if (present[ev]) state <= S_OUT;
          else ev <= ev + IW'(1);
        end
        S_OUT: begin
          if (slot_free) begin
            if (remain == CW'(1)) begin
              state <= S_IDLE;
            end else begin
              remain <= remain - CW'(1);
              ev <= ev + IW'(1);
              state <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> sv/conflict_graph_greedy_coloring_core.sv
// Top level of the conflict graph greedy coloring block.
// Add vertex and add edge commands each return one acknowledgement; an edge insert does a
// read-modify-write of both adjacency rows and degree counts through memories with one read
// and one write port. A color command selects the highest-degree uncolored vertex by a scan
// of the degree memory, then walks that vertex's adjacency row and the color memory vertex
// by vertex and searches the lowest free color one color a cycle, and repeats this for each
// present vertex, followed by one result per present vertex. A two-entry queue lets new
// commands be accepted while the back end is busy.
module conflict_graph_greedy_coloring_core #(
  parameter int MAX_VERTICES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  cgc_pkg::in_t  cmd,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  output cgc_pkg::out_t res,
  output logic          res_valid,
  input  logic          res_stall
);
  import cgc_pkg::*;

  localparam int NV = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t q_cmd;

  cgc_front #(.NV(NV)) u_front (
    .cmd(cmd),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .q_full(q_full),
    .push(push),
    .push_cmd(push_cmd)
  );

  cgc_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .din(push_cmd),
    .pop(pop),
    .dout(q_cmd),
    .full(q_full),
    .empty(q_empty)
  );

  cgc_back #(.NV(NV)) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_cmd(q_cmd),
    .pop(pop),
    .res(res),
    .res_valid(res_valid),
    .res_stall(res_stall)
  );
endmodule

>>> sv/cgc_checker.sv
// Port-level checker for the coloring block and its bind statement.
`include "assert_macros.svh"

module cgc_port_checker (
  input logic          clk,
  input logic          rst,
  input cgc_pkg::out_t res,
  input logic          res_valid,
  input logic          res_stall
);
  import cgc_pkg::*;

  logic ack_res;

  assign ack_res = res_valid && res.status != ST_OK;

  `ASSERT_CLK(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid && $stable(res))
  `ASSERT_CLK(a_ack_last, clk, rst, ack_res |-> res.last)
  `ASSERT_CLK(a_ack_zero, clk, rst, ack_res |-> res.vertex_id == '0 && res.assigned_color == '0)
  `ASSERT_ALWAYS(a_reset_clear, clk, $past(rst) |-> !res_valid)
endmodule

bind conflict_graph_greedy_coloring_core cgc_port_checker u_chk (.*);

>>> verif/cgc_checker.sv
// Checker for the conflict graph coloring block: predicts results per transfer and compares.
module cgc_checker (
  input  logic          clk,
  input  logic          rst,
  input  cgc_pkg::in_t  cmd,
  input  logic          cmd_valid,
  input  logic          cmd_stall,
  input  cgc_pkg::out_t res,
  input  logic          res_valid,
  input  logic          res_stall,
  output int            errors,
  output int            pending,
  output int            colorings,
  output int            results
);
  timeunit 1ns;
  timeprecision 1ps;
  import cgc_pkg::*;

  logic [63:0] present;
  logic [63:0] adj [64];
  logic [6:0]  degree [64];
  logic [5:0]  color_of [64];
  out_t        expected_q [$];

  function automatic out_t make_result(logic [5:0] id, logic [5:0] col, logic lst,
                                       logic [1:0] st);
    out_t r;
    r.vertex_id = id;
    r.assigned_color = col;
    r.last = lst;
    r.status = st;
    return r;
  endfunction

  task automatic add_expected(out_t r);
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic predict_coloring();
    logic [63:0] done;
    logic [63:0] used;
    int best;
    int n;
    logic [5:0] c;
    done = '0;
    n = $countones(present);
    if (n == 0) begin
      add_expected(make_result('0, '0, 1'b1, ST_EMPTY));
      return;
    end
    forever begin
      best = -1;
      for (int v = 0; v < 64; v++) begin
        if (present[v] && !done[v] && (best < 0 || degree[v] > degree[best])) begin
          best = v;
        end
      end
      if (best < 0) break;
      used = '0;
      for (int v = 0; v < 64; v++) begin
        if (adj[best][v] && done[v]) used[color_of[v]] = 1'b1;
      end
      c = LAST_COLOR;
      for (int k = 0; k < 64; k++) begin
        if (!used[k]) begin
          c = k[5:0];
          break;
        end
      end
      color_of[best] = c;
      done[best] = 1'b1;
    end
    for (int v = 0; v < 64; v++) begin
      if (present[v]) begin
        n--;
        add_expected(make_result(v[5:0], color_of[v], n == 0, ST_OK));
      end
    end
  endtask

  task automatic predict_command(in_t c);
    logic [1:0] st;
    st = ST_OK;
    case (c.opcode)
      OP_COLOR: begin
        colorings++;
        predict_coloring();
        return;
      end
      OP_ADD_VERTEX: begin
        present[c.vertex_a] = 1'b1;
      end
      OP_ADD_EDGE: begin
        if (c.vertex_a == c.vertex_b) begin
          st = ST_SELF_EDGE;
        end else begin
          present[c.vertex_a] = 1'b1;
          present[c.vertex_b] = 1'b1;
          if (!adj[c.vertex_a][c.vertex_b]) begin
            adj[c.vertex_a][c.vertex_b] = 1'b1;
            adj[c.vertex_b][c.vertex_a] = 1'b1;
            degree[c.vertex_a] = degree[c.vertex_a] + 7'd1;
            degree[c.vertex_b] = degree[c.vertex_b] + 7'd1;
          end
        end
      end
      default: begin
      end
    endcase
    add_expected(make_result('0, '0, 1'b1, st));
  endtask

  always_ff @(posedge clk) begin
    out_t exp_r;
    if (rst) begin
      present = '0;
      for (int v = 0; v < 64; v++) begin
        adj[v] = '0;
        degree[v] = '0;
        color_of[v] = '0;
      end
      expected_q.delete();
      errors <= 0;
      colorings = 0;
      results <= 0;
    end else begin
      if (cmd_valid && !cmd_stall) predict_command(cmd);
      if (res_valid && !res_stall) begin
        results <= results + 1;
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("MISMATCH: unexpected result %p", res);
          errors <= errors + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (res !== exp_r) begin
            if (errors < 10) $display("MISMATCH: expected %p, got %p", exp_r, res);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  assign pending = expected_q.size();

endmodule

>>> verif/testbench.sv
// Top of the testbench: clock, reset, stimulus, result stalls and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cgc_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic clk;
  logic rst;
  in_t  cmd;
  logic cmd_valid;
  logic cmd_stall;
  out_t res;
  logic res_valid;
  logic res_stall;
  int   errors;
  int   pending;
  int   colorings;
  int   results;
  int   sent;
  int   idle_cycles;
  int   stall_left;
  logic calm;

  conflict_graph_greedy_coloring_core #(.MAX_VERTICES(64)) i_dut (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .res(res), .res_valid(res_valid), .res_stall(res_stall)
  );

  cgc_checker i_checker (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .res(res), .res_valid(res_valid), .res_stall(res_stall),
    .errors(errors), .pending(pending), .colorings(colorings), .results(results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always_ff @(posedge clk) begin
    int w;
    if (rst) begin
      res_stall <= 1'b0;
      stall_left <= 0;
    end else if (res_valid && !res_stall) begin
      w = calm ? 0 : $urandom_range(0, 12);
      stall_left <= w;
      res_stall <= (w != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_stall <= (stall_left > 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [5:0] pick_vertex();
    return ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 15)) : 6'($urandom_range(0, 63));
  endfunction

  task automatic send(logic [1:0] op, logic [5:0] a, logic [5:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.opcode <= op;
    cmd.vertex_a <= a;
    cmd.vertex_b <= b;
    cmd_valid <= 1'b1;
    @(negedge clk);
    while (cmd_stall) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  initial begin
    int r;
    logic [5:0] a;
    logic [5:0] b;
    rst = 1'b1;
    cmd = '0;
    cmd_valid = 1'b0;
    calm = 1'b0;
    sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send(OP_COLOR, 6'd0, 6'd0);
    send(OP_ADD_VERTEX, 6'd0, 6'd63);
    send(OP_ADD_VERTEX, 6'd63, 6'd0);
    send(OP_COLOR, 6'd0, 6'd0);
    send(OP_ADD_EDGE, 6'd0, 6'd63);
    send(OP_ADD_EDGE, 6'd63, 6'd0);
    send(OP_ADD_EDGE, 6'd5, 6'd5);
    send(OP_ADD_EDGE, 6'd63, 6'd63);
    send(OP_ADD_EDGE, 6'd1, 6'd2);
    send(OP_ADD_EDGE, 6'd2, 6'd3);
    send(OP_ADD_EDGE, 6'd3, 6'd1);
    send(OP_ADD_EDGE, 6'd42, 6'd21);
    send(OP_ADD_VERTEX, 6'd21, 6'd42);
    send(OP_UNUSED, 6'd63, 6'd63);
    send(OP_ADD_VERTEX, 6'd0, 6'd0);
    send(OP_COLOR, 6'd63, 6'd63);

    cmd_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < 360; i++) begin
      if (i % 60 == 0) calm = ($urandom_range(0, 2) == 0);
      if (i == 200) begin
        cmd_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      a = pick_vertex();
      b = pick_vertex();
      if (r < 70) begin
        if (a == b) b = a + 6'd1;
        send(OP_ADD_EDGE, a, b);
      end else if (r < 82) begin
        send(OP_ADD_VERTEX, a, 6'($urandom_range(0, 63)));
      end else if (r < 88) begin
        send(OP_ADD_EDGE, a, a);
      end else if (r < 93) begin
        send(OP_UNUSED, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      end else begin
        send(OP_COLOR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      end
    end

    cmd_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d commands including %0d color commands; checked %0d results.",
             sent, colorings, results);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/cgc_pkg.sv
sv/cgc_front.sv
sv/cgc_queue.sv
sv/cgc_back.sv
sv/conflict_graph_greedy_coloring_core.sv
sv/cgc_checker.sv
verif/cgc_checker.sv
verif/testbench.sv
